// ===== rtl/core/nonpreemptive_job_scheduler_assert.svh =====
// Assertion macros used by the checker file of the job scheduler.
// Every macro samples on clk and is disabled while rst is high.
`ifndef NONPREEMPTIVE_JOB_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_JOB_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define NJS_ASSERT_IMP(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication.
`define NJS_ASSERT_NXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== rtl/core/njs_pkg.sv =====
// ----------------------------------------------------------------------------
// njs_pkg
// Types and constants shared by the non-preemptive job scheduler modules.
// ----------------------------------------------------------------------------
package njs_pkg;

  localparam int JOBS_DEF  = 16;
  localparam int JOBS_MAX  = 64;
  localparam int ARR_W     = 16;
  localparam int BURST_W   = 16;
  localparam int PRI_W     = 8;
  localparam int TICK_W    = 23;
  localparam int POS_W     = 4;
  localparam int RUN_CNT_W = $clog2(JOBS_MAX + 1);
  localparam int REC_W     = ARR_W + BURST_W + PRI_W;

  // Configuration register indexes.
  localparam logic REG_SELECT_MODE = 1'b0;

  // One job record as held in the job memory.
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   priority_lvl;
  } njs_rec_t;

  // One closed job set handed from the front to the back.
  typedef struct packed {
    logic                 mode;
    logic [RUN_CNT_W-1:0] count;
  } njs_run_t;

  // Exchange-sort order test: true when the record at the lower position
  // must trade places with the one at the higher position.
  function automatic logic must_swap(njs_rec_t lo, njs_rec_t hi, logic mode);
    logic res;
    res = 1'b0;
    if (lo.arrival > hi.arrival) res = 1'b1;
    if (mode && (lo.arrival == hi.arrival) && (lo.priority_lvl > hi.priority_lvl)) res = 1'b1;
    return res;
  endfunction

endpackage

// ===== rtl/core/njs_ram.sv =====
// ----------------------------------------------------------------------------
// njs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module njs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/njs_front.sv =====
// ----------------------------------------------------------------------------
// njs_front
// Takes job items, writes them into the job memory and closes a set on the
// last job or when the memory is full.
// ----------------------------------------------------------------------------
module njs_front import njs_pkg::*; #(
  parameter int JOBS = JOBS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [ARR_W-1:0]                       arrival_time,
  input  logic [BURST_W-1:0]                     burst_time,
  input  logic [PRI_W-1:0]                       priority_level,
  input  logic                                   last_job,
  input  logic                                   mode,
  output logic                                   wr_en,
  output logic [(JOBS > 1 ? $clog2(JOBS) : 1)-1:0] wr_addr,
  output njs_rec_t                               wr_rec,
  output logic                                   push,
  output njs_run_t                               push_run
);

  localparam int CNT_W = $clog2(JOBS + 1);
  localparam int IDX_W = JOBS > 1 ? $clog2(JOBS) : 1;

  logic [CNT_W-1:0] job_count;
  logic [CNT_W-1:0] count_next;
  logic             close;

  // Store the item at the next free slot.
  assign count_next = job_count + CNT_W'(1);
  assign close      = last_job || (count_next == CNT_W'(JOBS));
  assign wr_en      = accept;
  assign wr_addr    = job_count[IDX_W-1:0];
  assign wr_rec     = '{arrival: arrival_time, burst: burst_time, priority_lvl: priority_level};

  // A closing item hands the set to the back.
  assign push           = accept && close;
  assign push_run.mode  = mode;
  assign push_run.count = RUN_CNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count <= '0;
    end else if (accept) begin
      job_count <= close ? '0 : count_next;
    end
  end

endmodule

// ===== rtl/core/njs_queue.sv =====
// ----------------------------------------------------------------------------
// njs_queue
// Two-entry queue of closed job sets between the front and the back.
// ----------------------------------------------------------------------------
module njs_queue import njs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  njs_run_t push_run,
  input  logic     pop,
  output logic     valid,
  output njs_run_t head
);

  njs_run_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign valid = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_run;
  end

endmodule

// ===== rtl/core/njs_back.sv =====
// ----------------------------------------------------------------------------
// njs_back
// Sorts a closed job set in memory, simulates non-preemptive scheduling and
// emits one result item per sorted job.
// ----------------------------------------------------------------------------
module njs_back import njs_pkg::*; #(
  parameter int JOBS = JOBS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  njs_run_t                               q_head,
  output logic                                   q_pop,
  output logic [(JOBS > 1 ? $clog2(JOBS) : 1)-1:0] rd_addr,
  input  njs_rec_t                               rd_rec,
  output logic                                   wr_en,
  output logic [(JOBS > 1 ? $clog2(JOBS) : 1)-1:0] wr_addr,
  output njs_rec_t                               wr_rec,
  output logic                                   comp_we,
  output logic [(JOBS > 1 ? $clog2(JOBS) : 1)-1:0] comp_waddr,
  output logic [TICK_W-1:0]                      comp_wdata,
  input  logic [TICK_W-1:0]                      comp_rdata,
  output logic                                   active,
  output logic                                   result_valid,
  output logic [POS_W-1:0]                       position,
  output logic [ARR_W-1:0]                       job_arrival,
  output logic [BURST_W-1:0]                     job_burst,
  output logic [PRI_W-1:0]                       job_priority,
  output logic [TICK_W-1:0]                      completion_time,
  output logic [TICK_W-1:0]                      waiting_time,
  output logic [TICK_W-1:0]                      turnaround_time,
  output logic                                   last_result
);

  localparam int CNT_W = $clog2(JOBS + 1);
  localparam int IDX_W = JOBS > 1 ? $clog2(JOBS) : 1;

  typedef enum logic [3:0] {
    IDLE, S_LOADI, S_WAITI, S_RDJ, S_CMPJ, S_PUTI, C_RD, C_EVAL, C_STEP, E_RD, E_OUT
  } state_t;

  state_t              state;
  logic                mode;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    i;
  logic [CNT_W-1:0]    j;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    finished;
  njs_rec_t            cur;
  logic [TICK_W-1:0]   tick;
  logic [JOBS-1:0]     done;
  logic                have_pick;
  logic [IDX_W-1:0]    pick;
  logic [BURST_W-1:0]  best_key;
  logic [BURST_W-1:0]  pick_burst;
  logic [ARR_W-1:0]    min_arr;

  logic [BURST_W-1:0]  key;
  logic                ready;
  logic                swap;
  logic [TICK_W-1:0]   tick_next;
  logic [TICK_W-1:0]   turn;

  // Scan and sort decisions on the record just read.
  assign key       = mode ? BURST_W'(rd_rec.priority_lvl) : rd_rec.burst;
  assign ready     = !done[k[IDX_W-1:0]] && (TICK_W'(rd_rec.arrival) <= tick);
  assign swap      = must_swap(cur, rd_rec, mode);
  assign tick_next = tick + TICK_W'(pick_burst);
  assign turn      = comp_rdata - TICK_W'(rd_rec.arrival);

  // Memory addresses and write strobes follow the state.
  always_comb begin
    rd_addr = i[IDX_W-1:0];
    case (state)
      S_RDJ:   rd_addr = j[IDX_W-1:0];
      C_RD:    rd_addr = k[IDX_W-1:0];
      E_RD:    rd_addr = i[IDX_W-1:0];
      default: rd_addr = i[IDX_W-1:0];
    endcase
  end

  assign wr_en      = ((state == S_CMPJ) && swap) || (state == S_PUTI);
  assign wr_addr    = (state == S_PUTI) ? i[IDX_W-1:0] : j[IDX_W-1:0];
  assign wr_rec     = cur;
  assign comp_we    = (state == C_STEP) && have_pick;
  assign comp_waddr = pick;
  assign comp_wdata = tick_next;
  assign q_pop      = (state == IDLE) && q_valid;
  assign active     = (state != IDLE) || result_valid;

  // Sequencer: sort, schedule passes, then emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
      last_result  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      last_result  <= 1'b0;
      case (state)
        IDLE: begin
          if (q_valid) begin
            mode     <= q_head.mode;
            n        <= CNT_W'(q_head.count);
            i        <= '0;
            tick     <= '0;
            done     <= '0;
            finished <= '0;
            k        <= '0;
            have_pick <= 1'b0;
            min_arr  <= '1;
            state    <= (CNT_W'(q_head.count) > CNT_W'(1)) ? S_LOADI : C_RD;
          end
        end
        S_LOADI: state <= S_WAITI;
        S_WAITI: begin
          cur   <= rd_rec;
          j     <= i + CNT_W'(1);
          state <= S_RDJ;
        end
        S_RDJ: state <= S_CMPJ;
        S_CMPJ: begin
          if (swap) cur <= rd_rec;
          j     <= j + CNT_W'(1);
          state <= (j + CNT_W'(1) == n) ? S_PUTI : S_RDJ;
        end
        S_PUTI: begin
          i <= i + CNT_W'(1);
          if (i + CNT_W'(2) == n) begin
            k         <= '0;
            have_pick <= 1'b0;
            min_arr   <= '1;
            state     <= C_RD;
          end else begin
            state <= S_LOADI;
          end
        end
        C_RD: state <= C_EVAL;
        C_EVAL: begin
          if (ready && (!have_pick || key < best_key)) begin
            have_pick  <= 1'b1;
            pick       <= k[IDX_W-1:0];
            best_key   <= key;
            pick_burst <= rd_rec.burst;
          end
          if (!done[k[IDX_W-1:0]] && rd_rec.arrival < min_arr) min_arr <= rd_rec.arrival;
          k     <= k + CNT_W'(1);
          state <= (k + CNT_W'(1) == n) ? C_STEP : C_RD;
        end
        C_STEP: begin
          k         <= '0;
          have_pick <= 1'b0;
          min_arr   <= '1;
          state     <= C_RD;
          if (have_pick) begin
            tick       <= tick_next;
            done[pick] <= 1'b1;
            finished   <= finished + CNT_W'(1);
            if (finished + CNT_W'(1) == n) begin
              i     <= '0;
              state <= E_RD;
            end
          end else begin
            tick <= TICK_W'(min_arr);
          end
        end
        E_RD: state <= E_OUT;
        E_OUT: begin
          result_valid    <= 1'b1;
          last_result     <= (i + CNT_W'(1) == n);
          position        <= POS_W'(i);
          job_arrival     <= rd_rec.arrival;
          job_burst       <= rd_rec.burst;
          job_priority    <= rd_rec.priority_lvl;
          completion_time <= comp_rdata;
          turnaround_time <= turn;
          waiting_time    <= turn - TICK_W'(rd_rec.burst);
          i               <= i + CNT_W'(1);
          state           <= (i + CNT_W'(1) == n) ? IDLE : E_RD;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/nonpreemptive_job_scheduler.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_job_scheduler
// Non-preemptive shortest-job-first / priority scheduler over a loaded set.
// ----------------------------------------------------------------------------
// Jobs are loaded one item per cycle while busy is low; the item with
// last_job set, or the JOBS-th item, closes the set and raises busy. The back
// then sorts the set with an exchange sort, runs one scheduling pass per job
// completion or idle jump (each pass reads the records one at a time through
// the single read port of the job memory), and emits n result items. Results
// cannot be stalled; busy stays high until the last result has been shown.
// select_mode is sampled when a set closes.
module nonpreemptive_job_scheduler import njs_pkg::*; #(
  parameter int JOBS = JOBS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [ARR_W-1:0]     arrival_time,
  input  logic [BURST_W-1:0]   burst_time,
  input  logic [PRI_W-1:0]     priority_level,
  input  logic                 last_job,
  output logic                 result_valid,
  output logic [POS_W-1:0]     position,
  output logic [ARR_W-1:0]     job_arrival,
  output logic [BURST_W-1:0]   job_burst,
  output logic [PRI_W-1:0]     job_priority,
  output logic [TICK_W-1:0]    completion_time,
  output logic [TICK_W-1:0]    waiting_time,
  output logic [TICK_W-1:0]    turnaround_time,
  output logic                 last_result
);

  localparam int IDX_W = JOBS > 1 ? $clog2(JOBS) : 1;

  logic             select_mode;
  logic             accept;
  logic             q_valid;
  logic             q_pop;
  logic             push;
  njs_run_t         push_run;
  njs_run_t         q_head;
  logic             back_active;
  logic             f_we;
  logic [IDX_W-1:0] f_addr;
  njs_rec_t         f_rec;
  logic             b_we;
  logic [IDX_W-1:0] b_addr;
  njs_rec_t         b_rec;
  logic [IDX_W-1:0] rd_addr;
  njs_rec_t         rd_rec;
  logic             comp_we;
  logic [IDX_W-1:0] comp_waddr;
  logic [TICK_W-1:0] comp_wdata;
  logic [TICK_W-1:0] comp_rdata;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SELECT_MODE) ? {31'd0, select_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SELECT_MODE)) begin
      select_mode <= pwdata[0];
    end
  end

  // Handshake.
  assign accept = start && !busy;
  assign busy   = q_valid || back_active;

  njs_front #(.JOBS(JOBS)) u_front (
    .clk, .rst, .accept, .arrival_time, .burst_time, .priority_level, .last_job,
    .mode(select_mode), .wr_en(f_we), .wr_addr(f_addr), .wr_rec(f_rec),
    .push, .push_run
  );

  njs_queue u_queue (
    .clk, .rst, .push, .push_run, .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  // Job memory: the front writes while loading, the back while sorting.
  njs_ram #(.WIDTH(REC_W), .DEPTH(JOBS)) u_job_ram (
    .clk, .we(f_we || b_we), .waddr(b_we ? b_addr : f_addr),
    .wdata(b_we ? b_rec : f_rec), .raddr(rd_addr), .rdata(rd_rec)
  );

  njs_ram #(.WIDTH(TICK_W), .DEPTH(JOBS)) u_comp_ram (
    .clk, .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
    .raddr(rd_addr), .rdata(comp_rdata)
  );

  njs_back #(.JOBS(JOBS)) u_back (
    .clk, .rst, .q_valid, .q_head, .q_pop, .rd_addr, .rd_rec,
    .wr_en(b_we), .wr_addr(b_addr), .wr_rec(b_rec),
    .comp_we, .comp_waddr, .comp_wdata, .comp_rdata,
    .active(back_active), .result_valid, .position, .job_arrival, .job_burst,
    .job_priority, .completion_time, .waiting_time, .turnaround_time, .last_result
  );

endmodule

// ===== rtl/core/njs_checker.sv =====
// ----------------------------------------------------------------------------
// njs_checker
// Port-level checks of the job scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "nonpreemptive_job_scheduler_assert.svh"

module njs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_job,
  input logic result_valid,
  input logic last_result
);

  // Results only appear while the block reports itself busy.
  `NJS_ASSERT_IMP(a_result_busy, result_valid, busy, "result shown while not busy")
  // The last-result flag only rides on a result.
  `NJS_ASSERT_IMP(a_last_strobe, last_result, result_valid, "last_result without result")
  // A closing item starts a run.
  `NJS_ASSERT_NXT(a_close_busy, start && !busy && last_job, busy, "set closed but not busy")
  // Nothing follows the final result of a run in the next cycle.
  `NJS_ASSERT_NXT(a_last_end, result_valid && last_result, !result_valid, "result after last")

endmodule

bind nonpreemptive_job_scheduler njs_checker u_njs_checker (
  .clk, .rst, .start, .busy, .last_job, .result_valid, .last_result
);
